// ===== src/hpt_pkg.sv =====
`timescale 1ns / 1ps
package hpt_pkg;
    // matrix order, number of output lanes, quotient bits
    localparam int DIM   = 4;
    localparam int LANES = 3;
    localparam int QBITS = 32;
    localparam int IDX_W = 4;
    localparam int PT_W  = 32;

    // opcodes carried on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    // config register indexes
    localparam logic REG_MIN_T = 1'b0;

    // control traveling with each pipeline stage
    typedef struct packed {
        logic             valid;
        logic             degenerate;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] sat;
    } hpt_ctrl_t;
endpackage

// ===== src/hpt_mac.sv =====
`timescale 1ns / 1ps
module hpt_mac import hpt_pkg::*; #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int PW        = COEF_WIDTH + PT_W,
    localparam int AW        = PW + 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     in_op,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [31:0]       in_coef,
    input  logic signed [PT_W-1:0]   in_x,
    input  logic signed [PT_W-1:0]   in_y,
    input  logic signed [PT_W-1:0]   in_z,
    output logic                     out_valid,
    output logic [DIM-1:0][AW-1:0]   out_acc
);
    logic signed [COEF_WIDTH-1:0]       coef_reg [DIM*DIM];
    logic signed [PW-1:0]               prod_reg [DIM*DIM];
    logic signed [PT_W-1:0]             vec [DIM];
    logic                               p_valid_reg;
    logic                               s_valid_reg;
    logic [DIM-1:0][AW-1:0]             acc_reg;
    logic signed [COEF_WIDTH+31:0]      coef_ext;

    assign vec[0] = in_x;
    assign vec[1] = in_y;
    assign vec[2] = in_z;
    assign vec[3] = PT_W'(1) << FRAC_BITS;

    // sign-extend or wrap the 32-bit value to the stored width
    assign coef_ext = (COEF_WIDTH + 32)'(in_coef);

    // coefficient store, written by load transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIM*DIM; i++) coef_reg[i] <= '0;
        end else if (en && in_valid && in_op == OP_LOAD) begin
            coef_reg[in_idx] <= coef_ext[COEF_WIDTH-1:0];
        end
    end

    // stage 1: sixteen products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid && in_op == OP_XFORM;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < DIM; r++)
                for (int c = 0; c < DIM; c++)
                    prod_reg[r*DIM+c] <= PW'(coef_reg[r*DIM+c] * vec[c]);
        end
    end

    // stage 2: row sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg <= 1'b0;
        end else if (en) begin
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < DIM; r++)
                acc_reg[r] <= (AW'(prod_reg[r*DIM])   + AW'(prod_reg[r*DIM+1]))
                            + (AW'(prod_reg[r*DIM+2]) + AW'(prod_reg[r*DIM+3]));
        end
    end

    assign out_valid = s_valid_reg;
    assign out_acc   = acc_reg;
endmodule

// ===== src/hpt_prep.sv =====
`timescale 1ns / 1ps
module hpt_prep import hpt_pkg::*; #(
    parameter int AW        = 66,
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [DIM-1:0][AW-1:0]     in_acc,
    input  logic [30:0]                min_t,
    output hpt_ctrl_t                  out_ctrl,
    output logic [AW-1:0]              out_den,
    output logic [LANES-1:0][AW-1:0]   out_rem,
    output logic [LANES-1:0][QBITS-1:0] out_lo
);
    localparam int LW = AW + 32 + FRAC_BITS;
    localparam int NW = AW + FRAC_BITS;
    localparam int OW = AW + QBITS;

    logic [AW-1:0]              t_abs;
    logic [LANES-1:0][AW-1:0]   r_abs;
    logic [LANES-1:0][NW-1:0]   num;
    hpt_ctrl_t                  ctrl_next;
    hpt_ctrl_t                  ctrl_reg;
    logic [AW-1:0]              den_reg;
    logic [LANES-1:0][AW-1:0]   rem_reg;
    logic [LANES-1:0][QBITS-1:0] lo_reg;

    assign t_abs = in_acc[DIM-1][AW-1] ? AW'(-in_acc[DIM-1]) : in_acc[DIM-1];

    // magnitudes, signs, degenerate and overflow checks
    always_comb begin
        ctrl_next.valid      = in_valid;
        ctrl_next.degenerate = LW'(t_abs) <= (LW'(min_t) << FRAC_BITS);
        for (int l = 0; l < LANES; l++) begin
            r_abs[l] = in_acc[l][AW-1] ? AW'(-in_acc[l]) : in_acc[l];
            num[l]   = NW'(r_abs[l]) << FRAC_BITS;
            ctrl_next.neg[l] = in_acc[l][AW-1] ^ in_acc[DIM-1][AW-1];
            ctrl_next.sat[l] = OW'(r_abs[l]) >= (OW'(t_abs) << (QBITS - FRAC_BITS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= t_abs;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[l] <= AW'(num[l][NW-1:QBITS]);
                lo_reg[l]  <= num[l][QBITS-1:0];
            end
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_den  = den_reg;
    assign out_rem  = rem_reg;
    assign out_lo   = lo_reg;
endmodule

// ===== src/hpt_div_step.sv =====
`timescale 1ns / 1ps
module hpt_div_step import hpt_pkg::*; #(
    parameter int AW = 66
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  hpt_ctrl_t                   in_ctrl,
    input  logic [AW-1:0]               in_den,
    input  logic [LANES-1:0][AW-1:0]    in_rem,
    input  logic [LANES-1:0][QBITS-1:0] in_lo,
    output hpt_ctrl_t                   out_ctrl,
    output logic [AW-1:0]               out_den,
    output logic [LANES-1:0][AW-1:0]    out_rem,
    output logic [LANES-1:0][QBITS-1:0] out_lo
);
    hpt_ctrl_t                   ctrl_reg;
    logic [AW-1:0]               den_reg;
    logic [LANES-1:0][AW-1:0]    rem_reg;
    logic [LANES-1:0][QBITS-1:0] lo_reg;
    logic [LANES-1:0][AW:0]      trial;
    logic [LANES-1:0][AW:0]      diff;
    logic [LANES-1:0]            ge;

    // one restoring step per lane: quotient bit shifts in at the bottom of lo
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {in_rem[l], in_lo[l][QBITS-1]};
            diff[l]  = trial[l] - {1'b0, in_den};
            ge[l]    = trial[l] >= {1'b0, in_den};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= in_den;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[l] <= ge[l] ? diff[l][AW-1:0] : trial[l][AW-1:0];
                lo_reg[l]  <= {in_lo[l][QBITS-2:0], ge[l]};
            end
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_den  = den_reg;
    assign out_rem  = rem_reg;
    assign out_lo   = lo_reg;
endmodule

// ===== src/homogeneous_point_transform_core.sv =====
`timescale 1ns / 1ps
// Homogeneous 4x4 point transform with perspective divide. Load transactions
// (s_tuser = 0) write one Q16.16 matrix coefficient and give no result;
// transform transactions (s_tuser = 1) give one result per point: x, y, z
// divided by the homogeneous t, or zeros with the degenerate flag when |t|
// is not above min_t. One transaction is accepted every clock while the
// output side takes results. On its way to m_tvalid a transaction passes
// through products, row sums, sign/limit checks, one stage per quotient
// bit of the 32-bit divider, and the saturating output register. The whole
// pipeline advances together, so s_tready falls only while a result waits
// on m_tready. The matrix is cleared by reset; min_t resets to 1.
module homogeneous_point_transform_core import hpt_pkg::*; #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68],
    // point_z[131:100], zero fill
    input  logic [135:0] s_tdata,
    // opcode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_tdata,
    // degenerate
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = COEF_WIDTH + PT_W + 2;

    logic                        en;
    logic [30:0]                 min_t_reg;
    logic                        mac_valid;
    logic [DIM-1:0][AW-1:0]      mac_acc;
    hpt_ctrl_t                   ctrl   [QBITS+1];
    logic [AW-1:0]               den    [QBITS+1];
    logic [LANES-1:0][AW-1:0]    rem    [QBITS+1];
    logic [LANES-1:0][QBITS-1:0] lo     [QBITS+1];
    hpt_ctrl_t                   fin;
    logic [LANES-1:0][31:0]      res_next;
    logic                        m_tvalid_reg;
    logic [95:0]                 m_tdata_reg;
    logic                        m_tuser_reg;

    // whole pipeline moves unless a result is held at the output
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_T) ? {1'b0, min_t_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_t_reg <= 31'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_MIN_T) begin
            min_t_reg <= pwdata[30:0];
        end
    end

    hpt_mac #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser[0]),
        .in_idx    (s_tdata[3:0]),
        .in_coef   (s_tdata[35:4]),
        .in_x      (s_tdata[67:36]),
        .in_y      (s_tdata[99:68]),
        .in_z      (s_tdata[131:100]),
        .out_valid (mac_valid),
        .out_acc   (mac_acc)
    );

    hpt_prep #(.AW(AW), .FRAC_BITS(FRAC_BITS)) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (mac_valid),
        .in_acc   (mac_acc),
        .min_t    (min_t_reg),
        .out_ctrl (ctrl[0]),
        .out_den  (den[0]),
        .out_rem  (rem[0]),
        .out_lo   (lo[0])
    );

    // divider: one quotient bit per stage
    for (genvar k = 0; k < QBITS; k++) begin : g_div
        hpt_div_step #(.AW(AW)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctrl  (ctrl[k]),
            .in_den   (den[k]),
            .in_rem   (rem[k]),
            .in_lo    (lo[k]),
            .out_ctrl (ctrl[k+1]),
            .out_den  (den[k+1]),
            .out_rem  (rem[k+1]),
            .out_lo   (lo[k+1])
        );
    end

    assign fin = ctrl[QBITS];

    // sign and saturation
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (fin.degenerate) begin
                res_next[l] = 32'd0;
            end else if (fin.neg[l]) begin
                res_next[l] = (fin.sat[l] || lo[QBITS][l] > 32'h8000_0000)
                            ? 32'h8000_0000 : 32'd0 - lo[QBITS][l];
            end else begin
                res_next[l] = (fin.sat[l] || lo[QBITS][l] > 32'h7FFF_FFFF)
                            ? 32'h7FFF_FFFF : lo[QBITS][l];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {res_next[2], res_next[1], res_next[0]};
            m_tuser_reg <= fin.degenerate;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // checks
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 96'd0)
        else $error("degenerate result with nonzero coordinates");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr[2] == REG_MIN_T
        |=> min_t_reg == $past(pwdata[30:0]))
        else $error("min_t write lost");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import hpt_pkg::*;

    typedef struct {
        logic               opcode;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } vertex_cmd_t;

    typedef struct {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               degenerate;
    } vertex_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    homogeneous_point_transform_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // predictor state: coefficient store and threshold
    logic signed [31:0] coef_mem [16];
    logic [30:0]        min_t_q;

    vertex_cmd_t pending_cmds [$];
    vertex_res_t expected_vertices [$];
    int          mismatches = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int          src_gap = 0;
    int          sink_stall = 0;

    function automatic int draw_wait();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Q16.16 divide with truncation toward zero and 32-bit saturation
    function automatic logic [31:0] divide_sat(logic signed [127:0] row,
                                              logic signed [127:0] t);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        neg = (row < 0) != (t < 0);
        n = (row < 0) ? -row : row;
        d = (t < 0) ? -t : t;
        q = (n << 16) / d;
        if (neg)
            return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
        return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    // apply one command to the predictor; transforms yield one vertex
    function automatic void project_vertex(vertex_cmd_t c);
        logic signed [127:0] vec [4];
        logic signed [127:0] acc [4];
        logic signed [127:0] coef;
        logic [127:0]        tmag;
        logic [127:0]        lim;
        vertex_res_t         r;
        if (c.opcode == OP_LOAD) begin
            coef_mem[c.coef_index] = c.coef_value;
            return;
        end
        vec[0] = c.point_x;
        vec[1] = c.point_y;
        vec[2] = c.point_z;
        vec[3] = 128'sd65536;
        for (int i = 0; i < 4; i++) begin
            acc[i] = '0;
            for (int j = 0; j < 4; j++) begin
                coef = coef_mem[i * 4 + j];
                acc[i] = acc[i] + coef * vec[j];
            end
        end
        tmag = (acc[3] < 0) ? -acc[3] : acc[3];
        lim = {97'b0, min_t_q} << 16;
        if (tmag <= lim) begin
            r = '{0, 0, 0, 1'b1};
        end else begin
            r.out_x = divide_sat(acc[0], acc[3]);
            r.out_y = divide_sat(acc[1], acc[3]);
            r.out_z = divide_sat(acc[2], acc[3]);
            r.degenerate = 1'b0;
        end
        expected_vertices.push_back(r);
    endfunction

    // driver: source side changes on the falling edge
    always @(negedge aclk) begin
        vertex_cmd_t c;
        if (aresetn && !(s_tvalid && !in_taken)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_tdata <= {4'b0, c.point_z, c.point_y, c.point_x, c.coef_value,
                            c.coef_index};
                s_tuser <= c.opcode;
                s_tvalid <= 1'b1;
                src_gap <= draw_wait();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (aresetn) begin
            if (out_taken)
                sink_stall = draw_wait();
            if (sink_stall > 0) begin
                sink_stall = sink_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: sample both channels on the rising edge
    always @(posedge aclk) begin
        vertex_cmd_t c;
        vertex_res_t got;
        vertex_res_t exp_v;
        in_taken <= aresetn && s_tvalid && s_tready;
        out_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            c.coef_index = s_tdata[3:0];
            c.coef_value = s_tdata[35:4];
            c.point_x = s_tdata[67:36];
            c.point_y = s_tdata[99:68];
            c.point_z = s_tdata[131:100];
            c.opcode = s_tuser[0];
            project_vertex(c);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
            if (expected_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex %h deg %b", m_tdata, m_tuser);
            end else begin
                exp_v = expected_vertices.pop_front();
                if ({got.out_x, got.out_y, got.out_z, got.degenerate} !==
                    {exp_v.out_x, exp_v.out_y, exp_v.out_z, exp_v.degenerate}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: exp %h %h %h %b got %h %h %h %b",
                                 exp_v.out_x, exp_v.out_y, exp_v.out_z,
                                 exp_v.degenerate, got.out_x, got.out_y,
                                 got.out_z, got.degenerate);
                end
            end
        end
    end

    task automatic push_load(input logic [3:0] idx, input logic [31:0] val);
        pending_cmds.push_back('{OP_LOAD, idx, val, $urandom, $urandom, $urandom});
    endtask

    task automatic push_xform(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        pending_cmds.push_back('{OP_XFORM, 4'($urandom), $urandom, x, y, z});
    endtask

    // threshold register write, setup then access phase
    task automatic write_min_t(input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(REG_MIN_T) * 3'd4;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        min_t_q = val[30:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // checked on the rising edge, where the driver never pops or drives
    task automatic drain();
        while (pending_cmds.size() > 0 || s_tvalid || expected_vertices.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic logic [31:0] rand_t_coef();
        if ($urandom_range(0, 7) == 0)
            return rand_q();
        return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
    endfunction

    task automatic random_phase(input int n);
        logic [3:0] idx;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom;
                push_load(idx, (idx >= 12) ? rand_t_coef() : rand_q());
            end else begin
                push_xform(rand_q(), rand_q(), rand_q());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++)
            coef_mem[i] = '0;
        min_t_q = 31'd1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero matrix: t is zero, so degenerate
        push_xform(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        // identity matrix
        for (int i = 0; i < 4; i++)
            push_load(4'(i * 5), 32'h0001_0000);
        push_xform(32'h0001_8000, 32'hFFFE_0000, 32'h0000_0001);
        push_xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        // tiny t just above threshold: quotients saturate
        push_load(4'd15, 32'h0000_0002);
        push_xform(32'h0100_0000, 32'hFF00_0000, 32'h0000_0000);
        // negative t flips signs
        push_load(4'd15, 32'hFFFF_0000);
        push_xform(32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF);
        // t at exactly min_t (1) is degenerate
        push_load(4'd15, 32'h0000_0001);
        push_xform(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        // t driven by the point through the bottom row
        push_load(4'd15, 32'h0000_0000);
        push_load(4'd14, 32'h8000_0000);
        push_xform(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_load(4'd12, 32'h7FFF_FFFF);
        push_xform(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();

        // threshold settings, extremes among them
        write_min_t(32'h0000_0000);
        random_phase(200);
        drain();
        write_min_t(32'h7FFF_FFFF);
        random_phase(200);
        drain();
        write_min_t(32'hFFFF_FFFF);
        random_phase(150);
        drain();
        write_min_t($urandom_range(0, 1 << 20));
        random_phase(250);
        drain();
        write_min_t(32'h0001_0000);
        random_phase(200);
        drain();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
